// ----- src/rpt_pkg.sv -----
// Package for the revolution period tachometer: widths, reset constants,
// controller state type, event codes and the command/status structs.
// No dependencies.
package rpt_pkg;

  localparam int AVG_SHIFT = 4;
  localparam int STAMP_W   = 32;
  localparam int SCALE_W   = 31;
  localparam int SPEED_W   = 31;
  localparam int CNT_W     = AVG_SHIFT;
  localparam int AVG_W     = STAMP_W - AVG_SHIFT;
  localparam int DIV_STEPS = SPEED_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [SCALE_W-1:0] RPM_SCALE_RESET = SCALE_W'(411428571);

  // Event codes carried by the mode field of an input item.
  localparam logic EV_MARK = 1'b0;
  localparam logic EV_STOP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } rpt_state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_init;
    logic div_step;
    logic emit;
  } rpt_cmd_t;

  typedef struct packed {
    logic is_stop;
    logic group_done;
    logic out_free;
  } rpt_status_t;

endpackage

// ----- src/rpt_if.sv -----
// Valid/ready channel interfaces for the tachometer: event input and speed output.
// Depends on rpt_pkg.
interface rpt_in_if import rpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, mode, stamp, input ready);
  modport sink   (input valid, mode, stamp, output ready);
endinterface

interface rpt_out_if import rpt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed;
  logic               stopped;

  modport source (output valid, speed, stopped, input ready);
  modport sink   (input valid, speed, stopped, output ready);
endinterface

// ----- src/rpt_ctrl.sv -----
// Controller of the tachometer: state machine and divider step counter.
// Depends on rpt_pkg; drives the datapath through rpt_cmd_t.
module rpt_ctrl import rpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rpt_status_t status,
  output rpt_cmd_t    cmd
);

  rpt_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.is_stop)         state_nxt = ST_EMIT;
        else if (status.group_done) state_nxt = ST_DIV_INIT;
        else                        state_nxt = ST_IDLE;
      end
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (state_r == ST_DIV_INIT) step_nxt = '0;
    else if (state_r == ST_DIV) step_nxt = step_r + STEP_W'(1);
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_UPDATE:   cmd.update   = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_EMIT:     cmd.emit     = status.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

// ----- src/rpt_datapath.sv -----
// Datapath of the tachometer: event capture, interval accumulation, restoring
// divider and output register. Depends on rpt_pkg; commanded by rpt_ctrl.
module rpt_datapath import rpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rpt_cmd_t           cmd,
  output rpt_status_t        status,
  input  logic               in_mode,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SPEED_W-1:0] out_speed,
  output logic               out_stopped
);

  logic               mode_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] prev_r;
  logic [STAMP_W-1:0] sum_r;
  logic [CNT_W-1:0]   count_r;
  logic [SCALE_W-1:0] scale_r;
  logic [AVG_W-1:0]   dvsr_r;
  logic [AVG_W-1:0]   rem_r, rem_nxt;
  logic [SPEED_W-1:0] quo_r, quo_nxt;
  logic               out_valid_r;
  logic [SPEED_W-1:0] speed_r;
  logic               stopped_r;

  logic [AVG_W:0]     trial;
  logic [AVG_W:0]     diff;
  logic               ge;

  // One restoring step; a zero divisor gives all ones, the saturated speed.
  always_comb begin
    trial   = {rem_r, quo_r[SPEED_W-1]};
    diff    = trial - {1'b0, dvsr_r};
    ge      = (trial >= {1'b0, dvsr_r});
    rem_nxt = ge ? diff[AVG_W-1:0] : trial[AVG_W-1:0];
    quo_nxt = {quo_r[SPEED_W-2:0], ge};
  end

  always_comb begin
    status.is_stop    = mode_r;
    status.group_done = !mode_r && (prev_r != '0) && (count_r == '1);
    status.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      stamp_r <= in_stamp;
    end
    if (cmd.div_init) begin
      dvsr_r <= sum_r[STAMP_W-1:AVG_SHIFT];
      rem_r  <= '0;
      quo_r  <= scale_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.emit) begin
      speed_r   <= mode_r ? '0 : quo_r;
      stopped_r <= mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      scale_r     <= RPM_SCALE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) scale_r <= cfg_wr_data;
      if (cmd.update) begin
        if (mode_r) begin
          prev_r  <= '0;
          sum_r   <= '0;
          count_r <= '0;
        end else begin
          // Measure only when a previous mark is on record.
          if (prev_r != '0) begin
            sum_r   <= sum_r + (stamp_r - prev_r);
            count_r <= count_r + CNT_W'(1);
          end
          prev_r <= stamp_r;
        end
      end else if (cmd.div_init) begin
        sum_r <= '0;
      end
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (out_ready)    out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_speed   = speed_r;
  assign out_stopped = stopped_r;

endmodule

// ----- src/revolution_period_tachometer.sv -----
// Revolution period tachometer, top level.
// Input channel in_ch carries one event per item: mode 0 is a revolution mark
// with its free-running stamp, mode 1 is a stop. Output channel out_ch carries
// speed in RPM and a stopped flag. cfg_wr_en/cfg_wr_data write rpm_scale.
// A stop item yields speed 0 with stopped set. A mark yields a result only when
// it closes a group of 16 intervals; speed is rpm_scale over the mean interval,
// saturated to all ones when the mean is zero.
// Timing: an item is captured while the block idles and updates state in the next
// cycle. A mark that closes no group then returns to idle; a stop result moves on
// to the emit state and is registered there; a group result passes divider init and
// the 31-step radix-2 restoring divider, one quotient bit per cycle, then emit.
// One item is in work at a time; in_ch.ready is high while the block idles,
// also while a finished result waits in the output register.
// If the receiver stalls, a new result waits in its final state until the
// output register is free; no result is lost.
// Reset (rst_n low, synchronous) clears stored stamp, sum, count, the output
// valid flag and restores rpm_scale to its default.
// Depends on rpt_pkg, rpt_if, rpt_ctrl and rpt_datapath.
module revolution_period_tachometer import rpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rpt_in_if.sink             in_ch,
  rpt_out_if.source          out_ch,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data
);

  rpt_cmd_t    cmd;
  rpt_status_t status;

  rpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rpt_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_mode     (in_ch.mode),
    .in_stamp    (in_ch.stamp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_speed   (out_ch.speed),
    .out_stopped (out_ch.stopped)
  );

endmodule

// ----- tb/rpt_speed_checker.sv -----
`timescale 1ns / 1ps
// Checker for the revolution period tachometer: follows events, scale writes
// and results, predicts each speed item and compares it with the output.
// Depends on rpt_pkg and rpt_if.
module rpt_speed_checker import rpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rpt_in_if                  in_ch,
  rpt_out_if                 out_ch,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data,
  output int                 error_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               stopped;
  } speed_rec_t;

  logic [SCALE_W-1:0]  rpm_scale;
  logic [STAMP_W-1:0]  last_stamp;
  logic [STAMP_W-1:0]  period_sum;
  logic [CNT_W-1:0]    period_count;
  speed_rec_t          expected_speeds[$];

  // Advance the tachometer state by one event; queue the speed it yields.
  task automatic track_event(input logic mode_bit, input logic [STAMP_W-1:0] stamp_val);
    speed_rec_t          rec;
    logic [STAMP_W-1:0]  mean_period;
    if (mode_bit == EV_STOP) begin
      last_stamp   = '0;
      period_sum   = '0;
      period_count = '0;
      rec.speed    = '0;
      rec.stopped  = 1'b1;
      expected_speeds.push_back(rec);
    end else begin
      // a zero stamp on record means no earlier mark to measure from
      if (last_stamp != '0) begin
        period_sum   = period_sum + (stamp_val - last_stamp);
        period_count = period_count + CNT_W'(1);
        if (period_count == '0) begin
          mean_period = period_sum >> AVG_SHIFT;
          if (mean_period == '0)
            rec.speed = '1;
          else
            rec.speed = SPEED_W'(STAMP_W'(rpm_scale) / mean_period);
          rec.stopped = 1'b0;
          expected_speeds.push_back(rec);
          period_sum = '0;
        end
      end
      last_stamp = stamp_val;
    end
  endtask

  always @(posedge clk) begin
    speed_rec_t got;
    speed_rec_t want;
    if (!rst_n) begin
      rpm_scale    = RPM_SCALE_RESET;
      last_stamp   = '0;
      period_sum   = '0;
      period_count = '0;
      error_count  = 0;
      expected_speeds.delete();
    end else begin
      if (cfg_wr_en)
        rpm_scale = cfg_wr_data;
      if (in_ch.valid && in_ch.ready)
        track_event(in_ch.mode, in_ch.stamp);
      if (out_ch.valid && out_ch.ready) begin
        got.speed   = out_ch.speed;
        got.stopped = out_ch.stopped;
        if (expected_speeds.size() == 0) begin
          $display("%0t: unexpected item: speed %0d stopped %0b", $time, got.speed,
                   got.stopped);
          error_count++;
        end else begin
          want = expected_speeds.pop_front();
          if (got.speed !== want.speed || got.stopped !== want.stopped) begin
            $display("%0t: mismatch: expected speed %0d stopped %0b, got speed %0d stopped %0b",
                     $time, want.speed, want.stopped, got.speed, got.stopped);
            error_count++;
          end
        end
      end
    end
    pending_count <= expected_speeds.size();
  end

endmodule

// ----- tb/tb_revolution_period_tachometer.sv -----
`timescale 1ns / 1ps
// Testbench top for the revolution period tachometer: drives events and scale
// writes, paces the speed receiver and gives the verdict.
// Depends on rpt_pkg, rpt_if, rpt_speed_checker and the block itself.
module tb_revolution_period_tachometer;
  import rpt_pkg::*;

  localparam int   SETTLE_CYCLES = 40;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   PHASE_EVENTS  = 175;

  typedef enum int {GAP_TINY, GAP_TYPICAL, GAP_WIDE, GAP_STEADY} gap_kind_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [SCALE_W-1:0] cfg_wr_data;
  int                 error_count;
  int                 pending_count;
  int                 events_sent   = 0;
  int                 src_idle_pct  = 0;
  int                 sink_idle_pct = 0;
  int                 hold_seq      = 0;
  int                 hold_seen     = 0;
  int                 hold_left     = 0;

  rpt_in_if  in_ch();
  rpt_out_if out_ch();

  revolution_period_tachometer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  rpt_speed_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_event(input logic mode_bit, input logic [STAMP_W-1:0] stamp_val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode_bit;
    in_ch.stamp <= stamp_val;
    do
      @(posedge clk);
    while (!in_ch.ready);
    events_sent++;
  endtask

  // A run of marks with a chosen interval profile, now and then cut by a stop.
  task automatic send_mark_run();
    logic [STAMP_W-1:0] stamp_now;
    logic [STAMP_W-1:0] step_base;
    int                 n_marks;
    gap_kind_t          gap_kind;
    if ($urandom_range(1) == 1)
      send_event(EV_STOP, $urandom);
    n_marks   = $urandom_range(40, 17);
    gap_kind  = gap_kind_t'($urandom_range(3));
    stamp_now = $urandom;
    step_base = $urandom_range(32'h0010_0000, 1000);
    for (int i = 0; i < n_marks; i++) begin
      if ($urandom_range(99) < 3)
        send_event(EV_STOP, $urandom);
      send_event(EV_MARK, stamp_now);
      case (gap_kind)
        GAP_TINY:    stamp_now = stamp_now + $urandom_range(1);
        GAP_TYPICAL: stamp_now = stamp_now + $urandom_range(5000, 1);
        GAP_WIDE:    stamp_now = stamp_now + $urandom;
        default:     stamp_now = stamp_now + step_base + $urandom_range(64) - 32;
      endcase
    end
  endtask

  // Drop valid and let every expected item arrive, then let the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pick;
    int n_noise;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = EV_MARK;
    in_ch.stamp  = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        wait_drained();
        case (phase)
          1:       cfg_wr_data <= '1;
          2:       cfg_wr_data <= '0;
          3:       cfg_wr_data <= SCALE_W'(1);
          4:       cfg_wr_data <= SCALE_W'($urandom);
          default: cfg_wr_data <= RPM_SCALE_RESET;
        endcase
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
      end

      case (phase / 2)
        0: begin
          src_idle_pct  <= 22;
          sink_idle_pct <= 83;
        end
        1: begin
          src_idle_pct  <= 83;
          sink_idle_pct <= 22;
        end
        default: begin
          src_idle_pct  <= 0;
          sink_idle_pct <= 0;
        end
      endcase

      if (phase == 0) begin
        // extremes of the stamp, marks with nothing on record, zero mean period
        send_event(EV_STOP, '1);
        send_event(EV_MARK, '0);
        send_event(EV_MARK, '0);
        send_event(EV_MARK, 32'hFFFF_FFF0);
        repeat (16) send_event(EV_MARK, 32'hFFFF_FFF0);
        send_event(EV_MARK, 32'h0000_0010);
        send_event(EV_STOP, '0);
      end

      if (phase == 1) begin
        // hold the receiver off while stops pile up behind the output
        hold_seq <= hold_seq + 1;
        repeat (6) send_event(EV_STOP, $urandom);
      end

      while (events_sent < (phase + 1) * PHASE_EVENTS) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_mark_run();
        end else if (pick < 88) begin
          send_event(EV_STOP, $urandom);
        end else begin
          n_noise = $urandom_range(5, 1);
          repeat (n_noise)
            send_event(EV_MARK, ($urandom_range(4) == 0) ? 32'h0 : $urandom);
        end
      end
    end

    wait_drained();
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
